[rtl/bounded_key_set_swap_remove_assert.svh]
// Assertion macros for the bounded key set; they expand to nothing in synthesis.
`ifndef BOUNDED_KEY_SET_SWAP_REMOVE_ASSERT_SVH
`define BOUNDED_KEY_SET_SWAP_REMOVE_ASSERT_SVH
`ifndef SYNTHESIS
`define BKSET_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("bounded key set: forbidden condition seen");
`define BKSET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bounded key set: implication failed");
`define BKSET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bounded key set: next-cycle check failed");
`else
`define BKSET_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define BKSET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BKSET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bkset_pkg.sv]
// Types, constants and helper functions shared by the bounded key set modules.
`timescale 1ns / 1ps
`default_nettype none
package bkset_pkg;
	localparam int CAPACITY = 63;
	localparam int KEY_W = 32;
	localparam int COUNT_W = 6;
	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CONTAINS = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP_RD,
		ST_SWAP_WR
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic hit;
		logic accepted;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		logic [KEY_W-1:0] wdata;
		logic re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [COUNT_W-1:0] count_of(input logic [FILL_W-1:0] f);
		logic [FILL_W+COUNT_W-1:0] w;
		w = {{COUNT_W{1'b0}}, f};
		return w[COUNT_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_of(input logic [FILL_W-1:0] f);
		logic [FILL_W+IDX_W-1:0] w;
		w = {{IDX_W{1'b0}}, f};
		return w[IDX_W-1:0];
	endfunction
endpackage
`default_nettype wire

[rtl/bkset_ram.sv]
// Slot memory of the key set: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bkset_ram (
	input wire logic clk,
	input wire bkset_pkg::ram_req_t ram,
	output logic [bkset_pkg::KEY_W-1:0] rdata
);
	logic [bkset_pkg::KEY_W-1:0] mem [bkset_pkg::CAPACITY];
	logic [bkset_pkg::KEY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ram.we) begin
			mem[ram.waddr] <= ram.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ram.re) begin
			rdata_q <= mem[ram.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[rtl/bounded_key_set_swap_remove.sv]
// Top level of the bounded unordered key set with swap-remove.
`timescale 1ns / 1ps
`default_nettype none
// A request beat (req.func, req.key) is taken at a rising edge where start is
// high and busy is low. Each request yields exactly one result beat on rsp,
// marked by done for a single cycle; the receiver cannot hold results off.
// Add and clear, and a lookup on an empty set, give their result in the cycle
// after the request, and busy stays low, so a new request may follow at once.
// Contains and remove scan the slot memory from slot 0 upward, one slot per
// cycle through its single registered read port, and stop at the first match
// or after the last slot below the count. A remove that hits below the last
// slot then reads the last slot and writes it into the hole. Busy is high
// from the cycle after the request until the cycle before done.
// Reset clears the count and the control state; slot contents are not
// cleared, since only slots below the count are ever read.
module bounded_key_set_swap_remove (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire bkset_pkg::req_t req,
	output logic busy,
	output logic done,
	output bkset_pkg::rsp_t rsp
);
	bkset_pkg::state_t state_q, state_d;
	logic [bkset_pkg::FILL_W-1:0] fill_q, fill_d;
	logic [bkset_pkg::FILL_W-1:0] scan_q;
	logic [bkset_pkg::FILL_W-1:0] idx_s1;
	logic vld_s1;
	logic [bkset_pkg::IDX_W-1:0] pos_q;
	logic [1:0] func_q;
	logic [bkset_pkg::KEY_W-1:0] key_q;
	logic done_q, done_d;
	bkset_pkg::rsp_t rsp_q;
	logic hit_d, acc_d, accept, scan_rd;
	bkset_pkg::ram_req_t ram;
	logic [bkset_pkg::KEY_W-1:0] rdata;
	logic match, last;

	bkset_ram u_ram (
		.clk(clk),
		.ram(ram),
		.rdata(rdata)
	);

	assign match = vld_s1 && (rdata == key_q);
	assign last = (idx_s1 + bkset_pkg::FILL_W'(1)) == fill_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bkset_pkg::ST_IDLE: begin
				if (start && (req.func == bkset_pkg::OP_REMOVE ||
					req.func == bkset_pkg::OP_CONTAINS) && fill_q != '0) begin
					state_d = bkset_pkg::ST_SCAN;
				end
			end
			bkset_pkg::ST_SCAN: begin
				if (match) begin
					if (func_q == bkset_pkg::OP_REMOVE && !last) begin
						state_d = bkset_pkg::ST_SWAP_RD;
					end else begin
						state_d = bkset_pkg::ST_IDLE;
					end
				end else if (vld_s1 && last) begin
					state_d = bkset_pkg::ST_IDLE;
				end
			end
			bkset_pkg::ST_SWAP_RD: state_d = bkset_pkg::ST_SWAP_WR;
			bkset_pkg::ST_SWAP_WR: state_d = bkset_pkg::ST_IDLE;
			default: state_d = bkset_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram.we = 1'b0;
		ram.waddr = bkset_pkg::idx_of(fill_q);
		ram.wdata = req.key;
		ram.re = 1'b0;
		ram.raddr = bkset_pkg::idx_of(scan_q);
		fill_d = fill_q;
		done_d = 1'b0;
		hit_d = 1'b0;
		acc_d = 1'b0;
		accept = 1'b0;
		scan_rd = 1'b0;
		unique case (state_q)
			bkset_pkg::ST_IDLE: begin
				accept = start;
				if (start) begin
					unique case (req.func)
						bkset_pkg::OP_ADD: begin
							done_d = 1'b1;
							if (fill_q < bkset_pkg::CAP_FILL) begin
								ram.we = 1'b1;
								fill_d = fill_q + bkset_pkg::FILL_W'(1);
								acc_d = 1'b1;
							end
						end
						bkset_pkg::OP_REMOVE, bkset_pkg::OP_CONTAINS: begin
							done_d = (fill_q == '0);
						end
						bkset_pkg::OP_CLEAR: begin
							fill_d = '0;
							done_d = 1'b1;
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			bkset_pkg::ST_SCAN: begin
				scan_rd = (scan_q < fill_q) && !match;
				ram.re = scan_rd;
				if (match) begin
					hit_d = 1'b1;
					if (func_q == bkset_pkg::OP_REMOVE) begin
						fill_d = fill_q - bkset_pkg::FILL_W'(1);
						done_d = last;
					end else begin
						done_d = 1'b1;
					end
				end else if (vld_s1 && last) begin
					done_d = 1'b1;
				end
			end
			bkset_pkg::ST_SWAP_RD: begin
				ram.re = 1'b1;
				ram.raddr = bkset_pkg::idx_of(fill_q);
			end
			bkset_pkg::ST_SWAP_WR: begin
				ram.we = 1'b1;
				ram.waddr = pos_q;
				ram.wdata = rdata;
				hit_d = 1'b1;
				done_d = 1'b1;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bkset_pkg::ST_IDLE;
			fill_q <= '0;
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			scan_q <= '0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			done_q <= done_d;
			vld_s1 <= scan_rd;
			if (accept) begin
				scan_q <= '0;
			end else if (scan_rd) begin
				scan_q <= scan_q + bkset_pkg::FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q <= req.key;
		end
		idx_s1 <= scan_q;
		if (match) begin
			pos_q <= bkset_pkg::idx_of(idx_s1);
		end
		if (done_d) begin
			rsp_q.hit <= hit_d;
			rsp_q.accepted <= acc_d;
			rsp_q.count <= bkset_pkg::count_of(fill_d);
		end
	end

	assign busy = (state_q != bkset_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

`include "bounded_key_set_swap_remove_assert.svh"

	`BKSET_ASSERT_NEVER(a_fill_in_range, clk, arst_n, fill_q > bkset_pkg::CAP_FILL)
	`BKSET_ASSERT_IMPLY(a_done_when_idle, clk, arst_n, done_q, state_q == bkset_pkg::ST_IDLE)
	`BKSET_ASSERT_NEXT(a_add_stores, clk, arst_n,
		start && !busy && req.func == bkset_pkg::OP_ADD && fill_q < bkset_pkg::CAP_FILL,
		done_q && rsp_q.accepted)
	`BKSET_ASSERT_IMPLY(a_hit_on_lookup, clk, arst_n, done_q && rsp_q.hit,
		func_q == bkset_pkg::OP_REMOVE || func_q == bkset_pkg::OP_CONTAINS)
endmodule
`default_nettype wire

[dv/tb_bounded_key_set_swap_remove.sv]
// Self-checking testbench for the bounded unordered key set with swap-remove.
`timescale 1ns / 1ps
module tb_bounded_key_set_swap_remove;
	localparam int RESET_CYCLES = 12;
	localparam int KEY_POOL = 14;
	localparam int RANDOM_BEATS = 1890;
	localparam int SETTLE_CYCLES = bkset_pkg::CAPACITY + 16;
	localparam int unsigned CYCLE_LIMIT = 1500000;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	bkset_pkg::req_t req = '0;
	logic busy;
	logic done;
	bkset_pkg::rsp_t rsp;

	logic [bkset_pkg::KEY_W-1:0] held_keys [bkset_pkg::CAPACITY];
	int held_count = 0;
	logic [bkset_pkg::KEY_W-1:0] key_pool [KEY_POOL];
	bkset_pkg::rsp_t pending_rsps [$];
	bkset_pkg::rsp_t expected_rsp;
	int mismatches = 0;
	int beats_sent = 0;
	bit gaps_on = 1'b1;
	int unsigned cycle_count = 0;

	bounded_key_set_swap_remove i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Applies one request to the local copy of the set and returns its result beat.
	function automatic bkset_pkg::rsp_t predict_set_op(input bkset_pkg::req_t q);
		bkset_pkg::rsp_t r;
		int pos;
		int i;
		r = '0;
		pos = held_count;
		case (q.func)
			bkset_pkg::OP_ADD: begin
				if (held_count < bkset_pkg::CAPACITY) begin
					held_keys[held_count] = q.key;
					held_count++;
					r.accepted = 1'b1;
				end
			end
			bkset_pkg::OP_REMOVE, bkset_pkg::OP_CONTAINS: begin
				for (i = held_count - 1; i >= 0; i--)
					if (held_keys[i] == q.key)
						pos = i;
				if (pos < held_count) begin
					r.hit = 1'b1;
					if (q.func == bkset_pkg::OP_REMOVE) begin
						held_count--;
						held_keys[pos] = held_keys[held_count];
					end
				end
			end
			default: held_count = 0;
		endcase
		r.count = bkset_pkg::COUNT_W'(held_count);
		return r;
	endfunction

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(99, 0);
		if (sel < 50)
			return 0;
		if (sel < 88)
			return $urandom_range(3, 1);
		if (sel < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [bkset_pkg::KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(99, 0);
		if (sel < 45 && held_count > 0)
			return held_keys[$urandom_range(held_count - 1, 0)];
		if (sel < 85)
			return key_pool[$urandom_range(KEY_POOL - 1, 0)];
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_func(input int add_w, input int remove_w);
		int sel;
		sel = $urandom_range(99, 0);
		if (sel < 2)
			return bkset_pkg::OP_CLEAR;
		if (sel < 2 + add_w)
			return bkset_pkg::OP_ADD;
		if (sel < 2 + add_w + remove_w)
			return bkset_pkg::OP_REMOVE;
		return bkset_pkg::OP_CONTAINS;
	endfunction

	// Start stays high across back-to-back beats and is only lowered for a gap.
	task automatic send_req(input logic [1:0] f, input logic [bkset_pkg::KEY_W-1:0] k);
		int gap;
		start <= 1'b1;
		req <= '{func: f, key: k};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_rsps.push_back(predict_set_op('{func: f, key: k}));
		beats_sent++;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			req <= '{func: 2'($urandom), key: $urandom};
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_done();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsps.size() != 0);
	endtask

	task automatic test_directed();
		send_req(bkset_pkg::OP_CONTAINS, 32'h0000_0000);
		send_req(bkset_pkg::OP_REMOVE, 32'hFFFF_FFFF);
		send_req(bkset_pkg::OP_CLEAR, 32'hAAAA_5555);
		send_req(bkset_pkg::OP_ADD, 32'h0000_0000);
		send_req(bkset_pkg::OP_ADD, 32'hFFFF_FFFF);
		send_req(bkset_pkg::OP_ADD, 32'h0000_0000);
		send_req(bkset_pkg::OP_ADD, 32'h5A5A_5A5A);
		send_req(bkset_pkg::OP_CONTAINS, 32'hFFFF_FFFF);
		send_req(bkset_pkg::OP_CONTAINS, 32'h1234_5678);
		send_req(bkset_pkg::OP_REMOVE, 32'h0000_0000);
		send_req(bkset_pkg::OP_CONTAINS, 32'h0000_0000);
		send_req(bkset_pkg::OP_REMOVE, 32'h0000_0000);
		send_req(bkset_pkg::OP_CONTAINS, 32'h0000_0000);
		send_req(bkset_pkg::OP_REMOVE, 32'h0000_0000);
		send_req(bkset_pkg::OP_REMOVE, 32'h5A5A_5A5A);
		send_req(bkset_pkg::OP_REMOVE, 32'hFFFF_FFFF);
		send_req(bkset_pkg::OP_ADD, 32'h8000_0001);
		send_req(bkset_pkg::OP_CLEAR, 32'hFFFF_FFFF);
		send_req(bkset_pkg::OP_CONTAINS, 32'h8000_0001);
		wait_all_done();
	endtask

	task automatic test_full_capacity();
		int n;
		send_req(bkset_pkg::OP_CLEAR, $urandom);
		for (n = 0; n < bkset_pkg::CAPACITY; n++)
			send_req(bkset_pkg::OP_ADD, pick_key());
		send_req(bkset_pkg::OP_ADD, 32'h0000_0000);
		send_req(bkset_pkg::OP_ADD, 32'hFFFF_FFFF);
		send_req(bkset_pkg::OP_ADD, $urandom);
		for (n = 0; n < 8; n++)
			send_req(bkset_pkg::OP_CONTAINS, pick_key());
		send_req(bkset_pkg::OP_REMOVE, held_keys[held_count - 1]);
		send_req(bkset_pkg::OP_REMOVE, held_keys[0]);
		send_req(bkset_pkg::OP_ADD, $urandom);
		send_req(bkset_pkg::OP_ADD, $urandom);
		send_req(bkset_pkg::OP_ADD, $urandom);
		while (held_count > 0)
			send_req(bkset_pkg::OP_REMOVE, held_keys[$urandom_range(held_count - 1, 0)]);
		send_req(bkset_pkg::OP_CONTAINS, pick_key());
		send_req(bkset_pkg::OP_REMOVE, pick_key());
		wait_all_done();
	endtask

	task automatic test_random_mix();
		int round_len;
		int mode;
		int add_w;
		int remove_w;
		int n;
		while (beats_sent < RANDOM_BEATS) begin
			round_len = $urandom_range(120, 30);
			mode = $urandom_range(2, 0);
			add_w = (mode == 0) ? 60 : (mode == 1) ? 15 : 35;
			remove_w = (mode == 0) ? 20 : (mode == 1) ? 55 : 30;
			gaps_on = ($urandom_range(3, 0) != 0);
			for (n = 0; n < round_len; n++)
				send_req(pick_func(add_w, remove_w), pick_key());
			if ($urandom_range(3, 0) == 0)
				wait_all_done();
		end
		gaps_on = 1'b1;
		wait_all_done();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: result beat with none expected, actual %p", $time, rsp);
				mismatches++;
			end else begin
				expected_rsp = pending_rsps.pop_front();
				if (rsp.hit !== expected_rsp.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time,
						expected_rsp.hit, rsp.hit);
					mismatches++;
				end
				if (rsp.accepted !== expected_rsp.accepted) begin
					$display("%0t: accepted expected %0b actual %0b", $time,
						expected_rsp.accepted, rsp.accepted);
					mismatches++;
				end
				if (rsp.count !== expected_rsp.count) begin
					$display("%0t: count expected %0d actual %0d", $time,
						expected_rsp.count, rsp.count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int p = 2; p < KEY_POOL; p++)
			key_pool[p] = $urandom;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_capacity();
		test_random_mix();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rsps.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
